// ===== sv/skt_pkg.sv =====
package skt_pkg;

    localparam int TABLE_DEPTH_DEF   = 32;
    localparam int KEY_WIDTH_DEF     = 64;
    localparam int PAYLOAD_WIDTH_DEF = 32;

    typedef enum logic [2:0] {
        REQ_INSERT = 3'd0,
        REQ_DELETE = 3'd1,
        REQ_FIND   = 3'd2,
        REQ_READ   = 3'd3,
        REQ_UPDATE = 3'd4
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_BAD_POS   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        CELL_HOLD      = 2'd0,
        CELL_FROM_PREV = 2'd1,
        CELL_FROM_NEXT = 2'd2,
        CELL_LOAD      = 2'd3
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_CMP   = 3'b010,
        S_APPLY = 3'b100
    } t_state;

endpackage

// ===== sv/sorted_key_table.sv =====
// sorted key table: a row of compare-and-shift cells, one per entry
// an accepted word is registered, the cells register their compare in S_CMP, and
// S_APPLY shifts the cells and registers the result word once the output is free;
//   a word is taken only in S_IDLE, while the result register holds the last result
// reset: synchronous active-low reset empties the table and clears control state;
//   entry contents are not cleared
module sorted_key_table #(
    parameter int TABLE_DEPTH   = skt_pkg::TABLE_DEPTH_DEF,
    parameter int KEY_WIDTH     = skt_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [2:0]                        i_req_type,
    input  logic [KEY_WIDTH-1:0]              i_key,
    input  logic [PAYLOAD_WIDTH-1:0]          i_payload,
    input  logic [$clog2(TABLE_DEPTH)-1:0]    i_position,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [1:0]                        o_status,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_found_position,
    output logic [KEY_WIDTH-1:0]              o_key_out,
    output logic [PAYLOAD_WIDTH-1:0]          o_payload_out,
    output logic [$clog2(TABLE_DEPTH+1)-1:0]  o_entry_count
);
    import skt_pkg::*;

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    t_state                   r_state;
    t_state                   n_state;
    logic [2:0]               r_req;
    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic [IDX_W-1:0]         r_pos;
    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic                     r_out_valid;
    logic [1:0]               r_status;
    logic [IDX_W-1:0]         r_fpos;
    logic [KEY_WIDTH-1:0]     r_key_out;
    logic [PAYLOAD_WIDTH-1:0] r_payload_out;
    logic [CNT_W-1:0]         r_cnt_out;

    logic [1:0]               n_status;
    logic [IDX_W-1:0]         n_fpos;
    logic [KEY_WIDTH-1:0]     n_key_out;
    logic [PAYLOAD_WIDTH-1:0] n_payload_out;

    logic [KEY_WIDTH-1:0]     w_key [TABLE_DEPTH];
    logic [PAYLOAD_WIDTH-1:0] w_payload [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]   w_gt;
    logic [TABLE_DEPTH-1:0]   w_eq;
    t_cell_op                 w_op [TABLE_DEPTH];

    logic                     in_fire;
    logic                     apply_go;
    logic                     full;
    logic                     pos_ok;
    logic [IDX_W-1:0]         ins_idx;
    logic [IDX_W-1:0]         hit_idx;
    logic                     hit_any;
    logic [IDX_W-1:0]         rd_idx;
    logic [KEY_WIDTH-1:0]     rd_key;
    logic [PAYLOAD_WIDTH-1:0] rd_payload;

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;
    assign apply_go   = (r_state == S_APPLY) && (!r_out_valid || i_out_ready);
    assign full       = (r_count == CNT_W'(TABLE_DEPTH));
    assign pos_ok     = CNT_W'(r_pos) < r_count;

    // first entry not below the probe, and first exact match
    always_comb begin
        ins_idx = r_count[IDX_W-1:0];
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
            if (CNT_W'(i) < r_count) begin
                if (!w_gt[i]) begin
                    ins_idx = IDX_W'(i);
                end
                if (w_eq[i]) begin
                    hit_idx = IDX_W'(i);
                    hit_any = 1'b1;
                end
            end
        end
    end

    assign rd_idx = (r_req == REQ_FIND) ? hit_idx : r_pos;

    always_comb begin
        rd_key     = '0;
        rd_payload = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (rd_idx == IDX_W'(i)) begin
                rd_key     = w_key[i];
                rd_payload = w_payload[i];
            end
        end
    end

    always_comb begin
        n_status      = ST_OK;
        n_fpos        = '0;
        n_key_out     = '0;
        n_payload_out = '0;
        n_count       = r_count;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_op[i] = CELL_HOLD;
        end
        case (r_req)
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_fpos        = ins_idx;
                    n_key_out     = r_key;
                    n_payload_out = r_payload;
                    n_count       = r_count + CNT_W'(1);
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (IDX_W'(i) == ins_idx) begin
                            w_op[i] = CELL_LOAD;
                        end else if (IDX_W'(i) > ins_idx) begin
                            w_op[i] = CELL_FROM_PREV;
                        end
                    end
                end
            end
            REQ_DELETE: begin
                if (!pos_ok) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_fpos        = r_pos;
                    n_key_out     = rd_key;
                    n_payload_out = rd_payload;
                    n_count       = r_count - CNT_W'(1);
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (IDX_W'(i) >= r_pos) begin
                            w_op[i] = CELL_FROM_NEXT;
                        end
                    end
                end
            end
            REQ_FIND: begin
                if (!hit_any) begin
                    n_status = ST_NOT_FOUND;
                end else begin
                    n_fpos        = hit_idx;
                    n_key_out     = rd_key;
                    n_payload_out = rd_payload;
                end
            end
            REQ_READ: begin
                if (!pos_ok) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_fpos        = r_pos;
                    n_key_out     = rd_key;
                    n_payload_out = rd_payload;
                end
            end
            REQ_UPDATE: begin
                if (!pos_ok) begin
                    n_status = ST_BAD_POS;
                end else begin
                    n_fpos        = r_pos;
                    n_key_out     = r_key;
                    n_payload_out = r_payload;
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        if (IDX_W'(i) == r_pos) begin
                            w_op[i] = CELL_LOAD;
                        end
                    end
                end
            end
            default: begin
                n_status = ST_OK;
            end
        endcase
        if (!apply_go) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                w_op[i] = CELL_HOLD;
            end
        end
    end

    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? 0 : g - 1;
        localparam int NEXT = (g == TABLE_DEPTH - 1) ? g : g + 1;
        skt_cell #(
            .KEY_WIDTH     (KEY_WIDTH),
            .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
        ) u_cell (
            .i_clk          (i_clk),
            .i_op           (w_op[g]),
            .i_prev_key     (w_key[PREV]),
            .i_prev_payload (w_payload[PREV]),
            .i_next_key     (w_key[NEXT]),
            .i_next_payload (w_payload[NEXT]),
            .i_load_key     (r_key),
            .i_load_payload (r_payload),
            .i_probe_key    (r_key),
            .o_key          (w_key[g]),
            .o_payload      (w_payload[g]),
            .o_gt           (w_gt[g]),
            .o_eq           (w_eq[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_state = S_CMP;
                end
            end
            S_CMP: begin
                n_state = S_APPLY;
            end
            S_APPLY: begin
                if (apply_go) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (apply_go) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_req     <= i_req_type;
            r_key     <= i_key;
            r_payload <= i_payload;
            r_pos     <= i_position;
        end
        if (apply_go) begin
            r_status      <= n_status;
            r_fpos        <= n_fpos;
            r_key_out     <= n_key_out;
            r_payload_out <= n_payload_out;
            r_cnt_out     <= n_count;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_status         = r_status;
    assign o_found_position = r_fpos;
    assign o_key_out        = r_key_out;
    assign o_payload_out    = r_payload_out;
    assign o_entry_count    = r_cnt_out;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_word_from_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_APPLY))
        else $error("result word without an apply pass");

    a_accept_to_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |=> r_state == S_CMP)
        else $error("accepted word did not start a compare pass");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_status == ST_FULL) |-> r_cnt_out == CNT_W'(TABLE_DEPTH))
        else $error("table full reported below depth");

endmodule

// ===== sv/skt_cell.sv =====
module skt_cell #(
    parameter int KEY_WIDTH     = skt_pkg::KEY_WIDTH_DEF,
    parameter int PAYLOAD_WIDTH = skt_pkg::PAYLOAD_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  skt_pkg::t_cell_op        i_op,
    input  logic [KEY_WIDTH-1:0]     i_prev_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_prev_payload,
    input  logic [KEY_WIDTH-1:0]     i_next_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_next_payload,
    input  logic [KEY_WIDTH-1:0]     i_load_key,
    input  logic [PAYLOAD_WIDTH-1:0] i_load_payload,
    input  logic [KEY_WIDTH-1:0]     i_probe_key,
    output logic [KEY_WIDTH-1:0]     o_key,
    output logic [PAYLOAD_WIDTH-1:0] o_payload,
    output logic                     o_gt,
    output logic                     o_eq
);
    import skt_pkg::*;

    logic [KEY_WIDTH-1:0]     r_key;
    logic [PAYLOAD_WIDTH-1:0] r_payload;
    logic                     r_gt;
    logic                     r_eq;
    logic [KEY_WIDTH-1:0]     n_key;
    logic [PAYLOAD_WIDTH-1:0] n_payload;

    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        case (i_op)
            CELL_HOLD: begin
                n_key     = r_key;
                n_payload = r_payload;
            end
            CELL_FROM_PREV: begin
                n_key     = i_prev_key;
                n_payload = i_prev_payload;
            end
            CELL_FROM_NEXT: begin
                n_key     = i_next_key;
                n_payload = i_next_payload;
            end
            CELL_LOAD: begin
                n_key     = i_load_key;
                n_payload = i_load_payload;
            end
            default: begin
                n_key     = r_key;
                n_payload = r_payload;
            end
        endcase
    end

    // probe compare against the held entry
    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
        r_gt      <= i_probe_key > r_key;
        r_eq      <= i_probe_key == r_key;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;
    assign o_gt      = r_gt;
    assign o_eq      = r_eq;

endmodule

// ===== sim/skt_checker.sv =====
module skt_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [2:0]  i_req_type,
    input  logic [63:0] i_key,
    input  logic [31:0] i_payload,
    input  logic [4:0]  i_position,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [1:0]  i_status,
    input  logic [4:0]  i_found_position,
    input  logic [63:0] i_key_out,
    input  logic [31:0] i_payload_out,
    input  logic [5:0]  i_entry_count,
    output int          o_errors,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam int DEPTH = TABLE_DEPTH_DEF;

    typedef struct packed {
        t_status     status;
        logic [4:0]  position;
        logic [63:0] key;
        logic [31:0] payload;
        logic [5:0]  count;
    } t_table_result;

    logic [63:0]   key_mem [DEPTH];
    logic [31:0]   payload_mem [DEPTH];
    int            entries;
    t_table_result pending_results[$];
    t_table_result oldest;
    int            errors;

    assign o_errors = errors;

    function automatic t_table_result apply_request(input logic [2:0] req,
                                                    input logic [63:0] k,
                                                    input logic [31:0] pl,
                                                    input logic [4:0] pos);
        t_table_result r;
        int            i;
        r = '0;
        r.status = ST_OK;
        case (req)
            REQ_INSERT: begin
                if (entries >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    i = 0;
                    while (i < entries && k > key_mem[i]) i++;
                    for (int x = entries; x > i; x--) begin
                        key_mem[x]     = key_mem[x-1];
                        payload_mem[x] = payload_mem[x-1];
                    end
                    key_mem[i]     = k;
                    payload_mem[i] = pl;
                    entries++;
                    r.position = 5'(i);
                    r.key      = k;
                    r.payload  = pl;
                end
            end
            REQ_DELETE: begin
                if (pos >= entries) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.position = pos;
                    r.key      = key_mem[pos];
                    r.payload  = payload_mem[pos];
                    for (int x = pos; x + 1 < entries; x++) begin
                        key_mem[x]     = key_mem[x+1];
                        payload_mem[x] = payload_mem[x+1];
                    end
                    entries--;
                end
            end
            REQ_FIND: begin
                r.status = ST_NOT_FOUND;
                for (int x = 0; x < entries; x++) begin
                    if (key_mem[x] == k) begin
                        r.status   = ST_OK;
                        r.position = 5'(x);
                        r.key      = key_mem[x];
                        r.payload  = payload_mem[x];
                        break;
                    end
                end
            end
            REQ_READ: begin
                if (pos >= entries) begin
                    r.status = ST_BAD_POS;
                end else begin
                    r.position = pos;
                    r.key      = key_mem[pos];
                    r.payload  = payload_mem[pos];
                end
            end
            REQ_UPDATE: begin
                if (pos >= entries) begin
                    r.status = ST_BAD_POS;
                end else begin
                    key_mem[pos]     = k;
                    payload_mem[pos] = pl;
                    r.position = pos;
                    r.key      = k;
                    r.payload  = pl;
                end
            end
            default: begin
            end
        endcase
        r.count = 6'(entries);
        return r;
    endfunction

    task automatic report_error(input string what, input logic [63:0] got,
                                input logic [63:0] want);
        $display("error %s: got %0h want %0h at %0t", what, got, want, $time);
        errors++;
    endtask

    initial begin
        errors  = 0;
        entries = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            entries = 0;
            pending_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (pending_results.size() == 0) begin
                    report_error("result word with nothing pending", i_status, 0);
                end else begin
                    oldest = pending_results.pop_front();
                    if (i_status !== oldest.status)
                        report_error("status", i_status, oldest.status);
                    if (i_found_position !== oldest.position)
                        report_error("found_position", i_found_position, oldest.position);
                    if (i_key_out !== oldest.key)
                        report_error("key_out", i_key_out, oldest.key);
                    if (i_payload_out !== oldest.payload)
                        report_error("payload_out", i_payload_out, oldest.payload);
                    if (i_entry_count !== oldest.count)
                        report_error("entry_count", i_entry_count, oldest.count);
                end
            end
            if (i_in_valid && i_in_ready)
                pending_results.push_back(apply_request(i_req_type, i_key, i_payload,
                                                        i_position));
        end
        o_pending <= pending_results.size();
    end

endmodule

// ===== sim/tb_sorted_key_table.sv =====
module tb_sorted_key_table;
    timeunit 1ns;
    timeprecision 1ps;

    import skt_pkg::*;

    localparam logic [2:0] REQ_CODE_MAX = 3'h7;
    localparam int         IDLE_LIMIT   = 2000;
    localparam int         RANDOM_WORDS = 2000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  req_type = REQ_INSERT;
    logic [63:0] key = '0;
    logic [31:0] payload = '0;
    logic [4:0]  position = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic [4:0]  found_position;
    logic [63:0] key_out;
    logic [31:0] payload_out;
    logic [5:0]  entry_count;
    int          errors;
    int          pending;
    bit          no_gaps = 1'b0;
    int          idle_cycles = 0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_key_table dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_key            (key),
        .i_payload        (payload),
        .i_position       (position),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_status         (status),
        .o_found_position (found_position),
        .o_key_out        (key_out),
        .o_payload_out    (payload_out),
        .o_entry_count    (entry_count)
    );

    skt_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_req_type       (req_type),
        .i_key            (key),
        .i_payload        (payload),
        .i_position       (position),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_status         (status),
        .i_found_position (found_position),
        .i_key_out        (key_out),
        .i_payload_out    (payload_out),
        .i_entry_count    (entry_count),
        .o_errors         (errors),
        .o_pending        (pending)
    );

    task automatic send_word(input logic [2:0] req, input logic [63:0] k,
                             input logic [31:0] pl, input logic [4:0] pos);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_type <= req;
        key      <= k;
        payload  <= pl;
        position <= pos;
        in_valid <= 1'b1;
        do @(posedge clk); while (!(in_valid && in_ready));
        @(negedge clk);
    endtask

    function automatic logic [63:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0, 1, 2, 3: return 64'($urandom_range(0, 15));
            4: begin
                case ($urandom_range(0, 3))
                    0: return '0;
                    1: return '1;
                    2: return 64'h8000_0000_0000_0000;
                    default: return 64'h7fff_ffff_ffff_ffff;
                endcase
            end
            5: return {8'h41 + 8'($urandom_range(0, 3)), 56'h0};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [2:0] pick_request(input int phase);
        int r;
        r = $urandom_range(0, 99);
        case (phase)
            0: begin
                if (r < 65) return REQ_INSERT;
                if (r < 75) return REQ_FIND;
                if (r < 83) return REQ_READ;
                if (r < 90) return REQ_UPDATE;
                if (r < 97) return REQ_DELETE;
            end
            1: begin
                if (r < 15) return REQ_INSERT;
                if (r < 60) return REQ_DELETE;
                if (r < 72) return REQ_FIND;
                if (r < 82) return REQ_READ;
                if (r < 90) return REQ_UPDATE;
            end
            default: begin
                if (r < 30) return REQ_INSERT;
                if (r < 50) return REQ_DELETE;
                if (r < 68) return REQ_FIND;
                if (r < 82) return REQ_READ;
                if (r < 96) return REQ_UPDATE;
            end
        endcase
        return 3'($urandom_range(REQ_UPDATE + 1, REQ_CODE_MAX));
    endfunction

    initial begin
        logic [4:0] pos;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty table corners
        send_word(REQ_FIND, 64'h0, 32'h0, 5'd0);
        send_word(REQ_READ, 64'h0, 32'h0, 5'd0);
        send_word(REQ_DELETE, 64'h0, 32'h0, 5'd0);
        send_word(REQ_UPDATE, 64'h1, 32'h1, 5'd0);
        // key and payload extremes, duplicate key lands ahead
        send_word(REQ_INSERT, '1, '1, 5'd31);
        send_word(REQ_INSERT, '0, '0, 5'd0);
        send_word(REQ_INSERT, 64'h4142_4300_0000_0000, 32'h1111_1111, 5'd0);
        send_word(REQ_INSERT, 64'h4142_4300_0000_0000, 32'h2222_2222, 5'd0);
        send_word(REQ_FIND, 64'h4142_4300_0000_0000, 32'h0, 5'd0);
        send_word(REQ_FIND, 64'h4142_4400_0000_0000, 32'h0, 5'd0);
        send_word(REQ_READ, 64'h0, 32'h0, 5'd31);
        send_word(REQ_READ, 64'h0, 32'h0, 5'd2);
        send_word(REQ_UPDATE, 64'hffff_0000_ffff_0000, 32'h5a5a_a5a5, 5'd0);
        send_word(REQ_UPDATE, 64'h0, 32'h0, 5'd4);
        send_word(REQ_DELETE, 64'h0, 32'h0, 5'd3);
        send_word(REQ_DELETE, 64'h0, 32'h0, 5'd0);
        send_word(REQ_DELETE, 64'h0, 32'h0, 5'd2);
        for (int t = REQ_UPDATE + 1; t <= REQ_CODE_MAX; t++)
            send_word(3'(t), '1, '1, '1);
        send_word(REQ_READ, 64'h0, 32'h0, 5'd0);

        // fill, drain and mixed phases in turn
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n % 100 == 0)
                no_gaps = ($urandom_range(0, 3) == 0);
            pos = $urandom_range(0, 1) ? 5'($urandom_range(0, 31))
                                       : 5'($urandom_range(0, 7));
            send_word(pick_request((n / 100) % 3), pick_key(), $urandom, pos);
        end
        in_valid <= 1'b0;

        wait (pending == 0);
        repeat (10) @(posedge clk);
        if (errors == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        int gap;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 14);
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!(out_valid && out_ready));
            @(negedge clk);
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && in_ready) || (out_valid && out_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

endmodule

// ===== sim.f =====
sv/skt_pkg.sv
sv/skt_cell.sv
sv/sorted_key_table.sv
sim/skt_checker.sv
sim/tb_sorted_key_table.sv
